@@ sv/rrf_pkg.sv @@
// ============================================================================
// rrf_pkg
// Shared types and constants for the raster rectangle fill engine: command
// and result words, action codes, register indexes and the control/status
// bundles between the controller and the datapath.
// ============================================================================
package rrf_pkg;

   localparam int COORD_W     = 9;
   localparam int COLOR_W     = 8;
   localparam int ACTION_W    = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PIXEL = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_VLINE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_HLINE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RECT  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_HEIGHT = 4'd1;

   localparam logic [CSR_DATA_W-1:0] ACTIVE_SIZE_RESET = 9'd256;

   // character written by a clear
   localparam logic [COLOR_W-1:0] BLANK_PIXEL = 8'h4F;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COORD_W-1:0]  x_first;
      logic [COORD_W-1:0]  y_first;
      logic [COORD_W-1:0]  x_second;
      logic [COORD_W-1:0]  y_second;
      logic [COLOR_W-1:0]  color;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] read_color;
      logic               read_hit;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the accepted command word
      logic setup;     // compute clipped bounds, preset counters
      logic fill;      // write one pixel and step the counters
      logic out_load;  // load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;     // clipped area holds no pixel
      logic is_fill;   // command paints pixels
      logic last;      // counters sit on the final pixel
   } dp_status_type;

endpackage

@@ sv/raster_rect_fill_engine_top.sv @@
// ============================================================================
// raster_rect_fill_engine_top
// Byte-per-pixel frame store with a clear / pixel / line / rectangle / read
// drawing engine.
// ============================================================================
// Usage:
//   req_valid/req_stall/req_data carry one command word; it is taken at an
//   edge with req_valid high and req_stall low. One command runs at a time.
//   rsp_valid/rsp_stall/rsp_data return exactly one result word per command.
//   csr_valid/csr_ready/csr_index/csr_wdata write active_width (index 0) and
//   active_height (index 1); csr_ready is always high, write only when idle.
// Sequence:
//   An accepted command passes through setup and branch; the fill state
//   then paints its N clipped pixels, while reads, empty areas and unused
//   actions go straight to done. The result is loaded in done and the
//   controller returns to idle, where the next command is taken. Painting
//   runs one pixel per cycle through the single frame store write port;
//   a clear paints the whole active area clipped to MAX_COLS by MAX_ROWS.
// Reset: synchronous; idles the controller, drops rsp_valid and sets both
//   size registers to 256. The frame store is not cleared: issue a clear.
// Stall: a stalled result stays in the output register; the engine still
//   takes and runs the next command, holding its result until the slot frees.
// ============================================================================
module raster_rect_fill_engine_top #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rrf_pkg::req_word_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rrf_pkg::rsp_word_type           rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rrf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rrf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rrf_dpath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/rrf_dpath.sv @@
// ============================================================================
// rrf_dpath
// Datapath: command capture, active size registers, bound sorting and
// clipping, x/y scan counters, the frame store and the result register.
// ============================================================================
module rrf_dpath #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rrf_pkg::req_word_type                 req_data,
   input  logic                                  csr_write,
   input  logic [rrf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rrf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  rrf_pkg::ctrl_cmd_type                 cmd,
   output rrf_pkg::dp_status_type                status,
   output rrf_pkg::rsp_word_type                 rsp_data
);
   import rrf_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int PIX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [10:0] MAX_COLS_L = 11'(MAX_COLS);
   localparam logic [10:0] MAX_ROWS_L = 11'(MAX_ROWS);

   req_word_type          cmd_ff;
   logic [CSR_DATA_W-1:0] active_width_ff;
   logic [CSR_DATA_W-1:0] active_height_ff;
   logic [COORD_W-1:0]    x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;
   logic [COORD_W-1:0]    x_cnt_ff, y_cnt_ff;
   logic                  empty_ff, is_fill_ff, is_read_ff;
   logic [COLOR_W-1:0]    rd_data_ff;
   rsp_word_type          rsp_ff;
   logic [COLOR_W-1:0]    mem [DEPTH];

   logic [COORD_W-1:0]    lim_w, lim_h;
   logic [COORD_W-1:0]    xa, xb, ya, yb;
   logic [COORD_W-1:0]    x_lo_in, x_hi_in, y_lo_in, y_hi_in;
   logic                  valid_act;
   logic                  empty_in;
   logic [PIX_W-1:0]      pix_addr;

   // order two end points and clip them to 1..limit
   function automatic logic [2*COORD_W-1:0] clip_span(
      input logic [COORD_W-1:0] a,
      input logic [COORD_W-1:0] b,
      input logic [COORD_W-1:0] lim
   );
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (lo == '0) lo = COORD_W'(1);
      if (hi > lim) hi = lim;
      return {lo, hi};
   endfunction

   // clip limits: min(register, array size)
   assign lim_w = ({2'b00, active_width_ff} < MAX_COLS_L) ? active_width_ff
                                                           : COORD_W'(MAX_COLS);
   assign lim_h = ({2'b00, active_height_ff} < MAX_ROWS_L) ? active_height_ff
                                                            : COORD_W'(MAX_ROWS);

   // raw end points per action
   always_comb begin
      xa        = cmd_ff.x_first;
      xb        = cmd_ff.x_first;
      ya        = cmd_ff.y_first;
      yb        = cmd_ff.y_first;
      valid_act = 1'b1;
      unique case (cmd_ff.action)
         ACT_CLEAR: begin
            xa = COORD_W'(1);
            xb = lim_w;
            ya = COORD_W'(1);
            yb = lim_h;
         end
         ACT_PIXEL, ACT_READ: begin
         end
         ACT_VLINE: yb = cmd_ff.y_second;
         ACT_HLINE: xb = cmd_ff.x_second;
         ACT_RECT: begin
            xb = cmd_ff.x_second;
            yb = cmd_ff.y_second;
         end
         default: valid_act = 1'b0;
      endcase
   end

   assign {x_lo_in, x_hi_in} = clip_span(xa, xb, lim_w);
   assign {y_lo_in, y_hi_in} = clip_span(ya, yb, lim_h);
   assign empty_in = !valid_act || (x_lo_in > x_hi_in) || (y_lo_in > y_hi_in);

   // active size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= ACTIVE_SIZE_RESET;
         active_height_ff <= ACTIVE_SIZE_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_ACTIVE_WIDTH)  active_width_ff  <= csr_wdata;
         if (csr_index == CSR_ACTIVE_HEIGHT) active_height_ff <= csr_wdata;
      end
   end

   // command capture, bounds and scan counters
   always_ff @(posedge clock) begin
      if (cmd.load) cmd_ff <= req_data;
      if (cmd.setup) begin
         x_lo_ff    <= x_lo_in;
         x_hi_ff    <= x_hi_in;
         y_lo_ff    <= y_lo_in;
         y_hi_ff    <= y_hi_in;
         x_cnt_ff   <= x_lo_in;
         y_cnt_ff   <= y_lo_in;
         empty_ff   <= empty_in;
         is_fill_ff <= valid_act && (cmd_ff.action != ACT_READ);
         is_read_ff <= cmd_ff.action == ACT_READ;
      end else if (cmd.fill) begin
         if (x_cnt_ff == x_hi_ff) begin
            x_cnt_ff <= x_lo_ff;
            y_cnt_ff <= y_cnt_ff + COORD_W'(1);
         end else begin
            x_cnt_ff <= x_cnt_ff + COORD_W'(1);
         end
      end
   end

   // row-major pixel address of the scan position
   assign pix_addr = PIX_W'(PIX_W'(y_cnt_ff - COORD_W'(1)) * PIX_W'(MAX_COLS)
                           + PIX_W'(x_cnt_ff - COORD_W'(1)));

   // frame store: up to one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.fill) mem[pix_addr] <= (cmd_ff.action == ACT_CLEAR) ? BLANK_PIXEL
                                                                  : cmd_ff.color;
      rd_data_ff <= mem[pix_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.read_hit   <= is_read_ff && !empty_ff;
         rsp_ff.read_color <= (is_read_ff && !empty_ff) ? rd_data_ff : '0;
      end
   end

   assign rsp_data       = rsp_ff;
   assign status.empty   = empty_ff;
   assign status.is_fill = is_fill_ff;
   assign status.last    = (x_cnt_ff == x_hi_ff) && (y_cnt_ff == y_hi_ff);

`ifndef ASSERT_OFF
   // a write always lands inside the clipped span
   a_fill_in_span: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (x_cnt_ff >= x_lo_ff) && (x_cnt_ff <= x_hi_ff)
                   && (y_cnt_ff >= y_lo_ff) && (y_cnt_ff <= y_hi_ff))
      else $error("fill position outside clipped span");

   // never paint for an empty area or a read
   a_fill_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> !empty_ff && is_fill_ff && !is_read_ff)
      else $error("fill issued for an empty or non-paint command");

   // a non-empty span stays within the active area
   a_span_clipped: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (x_hi_ff <= lim_w) && (y_hi_ff <= lim_h) && (x_lo_ff != '0)
                   && (y_lo_ff != '0))
      else $error("clipped span exceeds active area");
`endif

endmodule

@@ sv/rrf_ctrl.sv @@
// ============================================================================
// rrf_ctrl
// Controller: sequences one command at a time through setup, scan and
// result hand-off, and owns both channel handshakes.
// ============================================================================
module rrf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rrf_pkg::dp_status_type status,
   output rrf_pkg::ctrl_cmd_type  cmd
);
   import rrf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BRANCH,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // commands decoded from state
   assign cmd.load     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.setup    = state_ff == ST_SETUP;
   assign cmd.fill     = state_ff == ST_FILL;
   assign cmd.out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load)   rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_SETUP;
            ST_SETUP:  state_ff <= ST_BRANCH;
            ST_BRANCH: state_ff <= (status.is_fill && !status.empty) ? ST_FILL : ST_DONE;
            ST_FILL:   if (status.last) state_ff <= ST_DONE;
            ST_DONE:   if (cmd.out_load) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // the final pixel ends the scan
   a_last_ends_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.fill && status.last) |=> (state_ff == ST_DONE))
      else $error("scan did not stop at last pixel");

   // an accepted command is followed by setup with the input held off
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (cmd.setup && req_stall))
      else $error("accepted command not set up");
`endif

endmodule
